/* rtl/reb_pkg.sv */
`default_nettype none

package reb_pkg;

   // Width of the debounce and hold counters
   localparam int COUNT_WIDTH = 16;
   // Width of the configuration registers
   localparam int CFG_WIDTH   = 16;
   // Common width for comparing a counter against a register
   localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_TICKS   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS_TICKS = 2'd1;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = 16'd50;
   localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd1000;

   typedef enum logic [2:0] {
      EV_NONE       = 3'd0,
      EV_ROTATE_CCW = 3'd1,
      EV_ROTATE_CW  = 3'd2,
      EV_CLICK      = 3'd3,
      EV_LONG_PRESS = 3'd4
   } event_type;

   // One sampled tick
   typedef struct packed {
      logic quad_a;
      logic quad_b;
      logic button_level;
   } tick_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] debounce_ticks;
      logic [CFG_WIDTH-1:0] long_press_ticks;
   } cfg_type;

   // Step for {previous AB, current AB}
   localparam logic signed [1:0] QUAD_STEPS [16] = '{
       2'sd0, -2'sd1,  2'sd1,  2'sd0,
       2'sd1,  2'sd0,  2'sd0, -2'sd1,
      -2'sd1,  2'sd0,  2'sd0,  2'sd1,
       2'sd0,  2'sd1, -2'sd1,  2'sd0
   };

endpackage

`default_nettype wire

/* rtl/reb_stream_if.sv */
`default_nettype none

interface reb_req_if;
   logic valid;
   logic ready;
   logic quad_a;
   logic quad_b;
   logic button_level;

   modport source (output valid, output quad_a, output quad_b, output button_level,
                   input ready);
   modport sink   (input valid, input quad_a, input quad_b, input button_level,
                   output ready);
endinterface

interface reb_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_code;

   modport source (output valid, output event_code, input ready);
   modport sink   (input valid, input event_code, output ready);
endinterface

`default_nettype wire

/* rtl/rotary_encoder_button_events.sv */
// A request is held in the input register once accepted and moves into the result
// register when that register is free or draining; its result is then offered to the sink.
// Throughput: one request per cycle; the input register refills while the result
// register drains, and it stalls only while a result waits on the sink.
// Reset (synchronous, active high) empties both registers, clears the encoder and
// button state and loads debounce 50 and long press 1000 ticks.
`default_nettype none

module rotary_encoder_button_events
   import reb_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   reb_req_if.sink                         req_chan,
   reb_rsp_if.source                       rsp_chan,
   input  wire logic                       csr_we,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CFG_WIDTH-1:0]       csr_wdata
);

   cfg_type   cfg_ff;
   logic      in_valid_ff;
   tick_type  tick_ff;
   logic      out_valid_ff;
   event_type out_event_ff, out_event_in;
   logic      advance;
   event_type quad_event;
   event_type button_event;

   // Move the held request on when the result register is free or draining
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   // Write the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks   <= DEBOUNCE_RESET;
         cfg_ff.long_press_ticks <= LONG_PRESS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEBOUNCE_TICKS:   cfg_ff.debounce_ticks   <= csr_wdata;
            CSR_LONG_PRESS_TICKS: cfg_ff.long_press_ticks <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         tick_ff.quad_a       <= req_chan.quad_a;
         tick_ff.quad_b       <= req_chan.quad_b;
         tick_ff.button_level <= req_chan.button_level;
      end
   end

   reb_quad u_quad (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .tick       (tick_ff),
      .quad_event (quad_event)
   );

   reb_button u_button (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .tick         (tick_ff),
      .cfg          (cfg_ff),
      .button_event (button_event)
   );

   // Button event takes priority over rotation
   assign out_event_in = (button_event != EV_NONE) ? button_event : quad_event;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_chan.ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_event_ff <= out_event_in;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.event_code = out_event_ff;

endmodule

`default_nettype wire

/* rtl/reb_quad.sv */
`default_nettype none

module reb_quad
   import reb_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      advance,
   input  wire tick_type  tick,
   output event_type      quad_event
);

   logic                pair_valid_ff, pair_valid_in;
   logic [1:0]          prev_pair_ff, prev_pair_in;
   logic signed [2:0]   step_sum_ff, step_sum_in;
   logic [1:0]          pair;
   logic signed [1:0]   step;
   logic signed [2:0]   sum;

   assign pair = {tick.quad_a, tick.quad_b};
   assign step = QUAD_STEPS[{prev_pair_ff, pair}];
   assign sum  = step_sum_ff + 3'(step);

   // Accumulate steps and fire on two in one direction
   always_comb begin
      pair_valid_in = 1'b1;
      prev_pair_in  = pair;
      step_sum_in   = step_sum_ff;
      quad_event    = EV_NONE;
      if (pair_valid_ff && step != 2'sd0) begin
         if (sum >= 3'sd2) begin
            step_sum_in = '0;
            quad_event  = EV_ROTATE_CCW;
         end else if (sum <= -3'sd2) begin
            step_sum_in = '0;
            quad_event  = EV_ROTATE_CW;
         end else begin
            step_sum_in = sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_valid_ff <= 1'b0;
         prev_pair_ff  <= 2'd3;
         step_sum_ff   <= '0;
      end else if (advance) begin
         pair_valid_ff <= pair_valid_in;
         prev_pair_ff  <= prev_pair_in;
         step_sum_ff   <= step_sum_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/reb_button.sv */
`default_nettype none

module reb_button
   import reb_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      advance,
   input  wire tick_type  tick,
   input  wire cfg_type   cfg,
   output event_type      button_event
);

   logic                   last_raw_ff, last_raw_in;
   logic                   stable_ff, stable_in;
   logic [COUNT_WIDTH-1:0] stable_count_ff, stable_count_in;
   logic [COUNT_WIDTH-1:0] hold_count_ff, hold_count_in;
   logic [COUNT_WIDTH-1:0] hold_step;
   logic                   raw;

   assign raw = tick.button_level;

   // Count the press, debounce the raw level, classify a release
   always_comb begin
      hold_step = hold_count_ff;
      if (!stable_ff && hold_count_ff != '1) begin
         hold_step = hold_count_ff + 1'b1;
      end
      if (raw != last_raw_ff) begin
         stable_count_in = '0;
      end else if (stable_count_ff != '1) begin
         stable_count_in = stable_count_ff + 1'b1;
      end else begin
         stable_count_in = stable_count_ff;
      end
      last_raw_in   = raw;
      stable_in     = stable_ff;
      hold_count_in = hold_step;
      button_event  = EV_NONE;
      if (CMP_WIDTH'(stable_count_in) >= CMP_WIDTH'(cfg.debounce_ticks) &&
          raw != stable_ff) begin
         stable_in = raw;
         if (!raw) begin
            hold_count_in = '0;
         end else if (CMP_WIDTH'(hold_step) >= CMP_WIDTH'(cfg.long_press_ticks)) begin
            button_event = EV_LONG_PRESS;
         end else begin
            button_event = EV_CLICK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff     <= 1'b1;
         stable_ff       <= 1'b1;
         stable_count_ff <= '0;
         hold_count_ff   <= '0;
      end else if (advance) begin
         last_raw_ff     <= last_raw_in;
         stable_ff       <= stable_in;
         stable_count_ff <= stable_count_in;
         hold_count_ff   <= hold_count_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/reb_checker.sv */
`default_nettype none

module reb_checker
   import reb_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_code
);

   // Nothing is offered straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // Only defined event codes leave the block
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_code == EV_NONE || rsp_code == EV_ROTATE_CCW ||
                     rsp_code == EV_ROTATE_CW || rsp_code == EV_CLICK ||
                     rsp_code == EV_LONG_PRESS))
      else $error("undefined event code");

   // An accepted request is offered on the output if the sink is ready while it waits in the input register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)
      else $error("request lost in the pipeline");

   // A stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_code)))
      else $error("stalled result changed");

endmodule

bind rotary_encoder_button_events reb_checker u_reb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_code  (rsp_chan.event_code)
);

`default_nettype wire
